@@ design/wbps_pkg.sv @@
// Package for the wildcard byte pattern scanner: widths, register codes and
// the structs passed between the configuration block and the match core.
// No dependencies.
`default_nettype none

package wbps_pkg;

    localparam int DEFAULT_PATTERN_BYTES = 16;
    localparam int CFG_PAT_BYTES         = 16;   // pattern positions with register bits
    localparam int ADDR_W                = 48;
    localparam int SEEN_W                = 32;
    localparam int LEN_W                 = 5;
    localparam int CFG_IDX_W             = 3;
    localparam int CFG_DATA_W            = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CARE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE     = 3'd4;

    typedef struct packed {
        logic [8*CFG_PAT_BYTES-1:0] pattern;
        logic [CFG_PAT_BYTES-1:0]   care;
        logic [LEN_W-1:0]           len;
        logic [ADDR_W-1:0]          base;
    } t_cfg;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] addr;
    } t_res;

endpackage

`default_nettype wire

@@ design/wbps_cfg.sv @@
// Configuration registers of the wildcard byte pattern scanner.
// Depends on wbps_pkg for register codes and the t_cfg struct.
`default_nettype none

module wbps_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [wbps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output wbps_pkg::t_cfg                       o_cfg
);

    wbps_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                wbps_pkg::REG_PAT_LOW: begin
                    r_cfg.pattern[63:0] <= i_cfg_data;
                end
                wbps_pkg::REG_PAT_HIGH: begin
                    r_cfg.pattern[127:64] <= i_cfg_data;
                end
                wbps_pkg::REG_CARE: begin
                    r_cfg.care <= i_cfg_data[wbps_pkg::CFG_PAT_BYTES-1:0];
                end
                wbps_pkg::REG_LEN: begin
                    r_cfg.len <= i_cfg_data[wbps_pkg::LEN_W-1:0];
                end
                wbps_pkg::REG_BASE: begin
                    r_cfg.base <= i_cfg_data[wbps_pkg::ADDR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ design/wbps_match.sv @@
// Match core: byte window, range byte counter, parallel masked compares and
// result formation for one byte per advancing cycle. Depends on wbps_pkg.
`default_nettype none

module wbps_match #(
    parameter int PATTERN_BYTES = wbps_pkg::DEFAULT_PATTERN_BYTES
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_adv,
    input  wire logic [7:0]     i_byte,
    input  wire logic           i_last,
    input  wire wbps_pkg::t_cfg i_cfg,
    output logic                o_has_res,
    output wbps_pkg::t_res      o_res
);

    localparam int LW = $clog2(PATTERN_BYTES + 1);
    localparam int CW = (PATTERN_BYTES > wbps_pkg::CFG_PAT_BYTES) ?
                        PATTERN_BYTES : wbps_pkg::CFG_PAT_BYTES;

    logic [7:0]                   r_win [PATTERN_BYTES];
    logic [7:0]                   shifted [PATTERN_BYTES];
    logic [wbps_pkg::SEEN_W-1:0]  r_seen;
    logic                         r_reported;

    logic [CW-1:0]                care_w;
    logic [8*CW-1:0]              pat_w;
    logic [PATTERN_BYTES-1:0]     care_ext;
    logic [8*PATTERN_BYTES-1:0]   pat_ext;
    logic [PATTERN_BYTES:0]       match_len;
    logic [LW-1:0]                len_eff;
    logic                         seen_ok;
    logic                         active;
    logic                         raw_hit;
    logic                         hit;
    logic [wbps_pkg::ADDR_W-1:0]  hit_addr;

    // Positions past the register bits are wildcards.
    assign care_w   = CW'(i_cfg.care);
    assign pat_w    = (8*CW)'(i_cfg.pattern);
    assign care_ext = care_w[PATTERN_BYTES-1:0];
    assign pat_ext  = pat_w[8*PATTERN_BYTES-1:0];

    assign len_eff = (32'(i_cfg.len) > 32'(PATTERN_BYTES)) ?
                     LW'(PATTERN_BYTES) : LW'(i_cfg.len);

    always_comb begin
        shifted[0] = i_byte;
        for (int j = 1; j < PATTERN_BYTES; j++) begin
            shifted[j] = r_win[j-1];
        end
    end

    // One match flag per candidate length; the configured length picks one.
    always_comb begin
        match_len[0] = 1'b1;
        for (int l = 1; l <= PATTERN_BYTES; l++) begin
            match_len[l] = 1'b1;
            for (int k = 0; k < l; k++) begin
                if (care_ext[k] && (shifted[l-1-k] != pat_ext[8*k +: 8])) begin
                    match_len[l] = 1'b0;
                end
            end
        end
    end

    assign seen_ok  = ({1'b0, r_seen} + 33'd1) >= 33'(len_eff);
    assign active   = !r_reported && (r_seen != '1);
    assign raw_hit  = (len_eff == '0) ? (r_seen == '0) : (seen_ok && match_len[len_eff]);
    assign hit      = active && raw_hit;
    assign hit_addr = (len_eff == '0) ? i_cfg.base :
                      (i_cfg.base + wbps_pkg::ADDR_W'(r_seen) + wbps_pkg::ADDR_W'(1)
                       - wbps_pkg::ADDR_W'(len_eff));

    // A match on the last byte suppresses the not-found result.
    assign o_has_res   = hit || (i_last && !r_reported);
    assign o_res.found = hit;
    assign o_res.addr  = hit ? hit_addr : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_reported <= 1'b0;
            for (int j = 0; j < PATTERN_BYTES; j++) begin
                r_win[j] <= 8'h00;
            end
        end else if (i_adv) begin
            if (i_last) begin
                r_seen     <= '0;
                r_reported <= 1'b0;
                for (int j = 0; j < PATTERN_BYTES; j++) begin
                    r_win[j] <= 8'h00;
                end
            end else begin
                if (active) begin
                    r_seen <= r_seen + 1'b1;
                    for (int j = 0; j < PATTERN_BYTES; j++) begin
                        r_win[j] <= shifted[j];
                    end
                end
                if (hit) begin
                    r_reported <= 1'b1;
                end
            end
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_last) |=> (r_seen == '0 && !r_reported))
        else $error("range state not cleared after last byte");

    a_reported_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !i_last && r_reported) |=> (r_reported && $stable(r_seen)))
        else $error("state changed after a reported match");

    a_seen_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !i_last && active) |=> (r_seen == $past(r_seen) + 1'b1))
        else $error("byte counter did not advance");

endmodule

`default_nettype wire

@@ design/wildcard_byte_pattern_scan.sv @@
// Wildcard byte pattern scanner, top level: input register, match core,
// configuration registers and result register. Depends on wbps_pkg,
// wbps_cfg and wbps_match.
//
// Usage: bytes of a memory range enter on the s_axis channel, one per
// transfer, with tlast on the final byte. The pattern, care mask, length and
// base address are written on the cfg channel (always ready) between ranges.
// Each range yields one result on m_axis: tuser=1 with the match address in
// tdata for the first complete match, or tuser=0 with zero address when the
// range ends without one. Bytes after a match are dropped until tlast.
// Throughput is one byte per cycle while the receiver keeps up; the window
// compares all run in parallel in the single stage between the input and
// result registers; a byte waits in the first, its result in the second.
// When the receiver stalls, the result register holds and the input register
// keeps one more byte; the s_axis side stalls only once both are full.
// Reset (synchronous, active low) clears the valid flags, the configuration
// registers, the window and the byte counter; no clearing pass follows.
`default_nettype none

module wildcard_byte_pattern_scan #(
    parameter int PATTERN_BYTES = wbps_pkg::DEFAULT_PATTERN_BYTES
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [7:0]                      s_axis_tdata,   // [7:0] data_byte
    input  wire logic                            s_axis_tlast,   // last
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [wbps_pkg::ADDR_W-1:0]          m_axis_tdata,   // [47:0] match_address
    output logic                                 m_axis_tuser,   // [0] found
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [wbps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    wbps_pkg::t_cfg cfg;
    wbps_pkg::t_res res;
    wbps_pkg::t_res r_out_res;
    logic           has_res;
    logic           adv;
    logic           r_in_valid;
    logic [7:0]     r_in_byte;
    logic           r_in_last;
    logic           r_out_valid;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    wbps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    wbps_match #(
        .PATTERN_BYTES (PATTERN_BYTES)
    ) u_match (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .i_cfg     (cfg),
        .o_has_res (has_res),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && has_res) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the result until its transfer completes.
    always_ff @(posedge i_clk) begin
        if (adv && has_res) begin
            r_out_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_res.addr;
    assign m_axis_tuser  = r_out_res.found;

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while both stages are full");

    a_result_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && has_res) |=> r_out_valid)
        else $error("result lost on its way to the output register");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_res.found) |-> (r_out_res.addr == '0))
        else $error("not-found result carries a nonzero address");

endmodule

`default_nettype wire
